// File: hw/rtl/vtcm_pkg.sv
// Shared types and constants of the value-to-colour overlay mapper.
`timescale 1ns / 1ps

package vtcm_pkg;

  localparam int COLORSCALE_ENTRIES = 256;
  localparam int MAX_PANES          = 32;
  localparam int CS_IDX_W           = $clog2(COLORSCALE_ENTRIES);
  localparam int PANE_ADDR_W        = $clog2(MAX_PANES);
  localparam int PANE_IDX_W         = $clog2(MAX_PANES + 1);
  localparam int QUEUE_DEPTH        = 4;
  localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W          = 3;

  localparam logic [63:0] ROUND_Q32 = 64'h0000_0000_7D70_A3D7;
  localparam logic [CS_IDX_W-1:0] CS_LAST = CS_IDX_W'(COLORSCALE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ACT_MAP        = 2'd0,
    ACT_CS_WRITE   = 2'd1,
    ACT_PANE_WRITE = 2'd2,
    ACT_UNUSED     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_PANE_COUNT = 3'd1,
    REG_BOTTOM     = 3'd2,
    REG_TOP        = 3'd3,
    REG_FACTOR     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    JOB_CS_WRITE,
    JOB_PANE_WRITE,
    JOB_MAP_CS,
    JOB_MAP_PANE,
    JOB_DROP
  } job_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_CS_RD,
    ST_SEARCH,
    ST_PANE_RD
  } back_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [23:0]        node_id;
    logic signed [31:0] value;
    logic               list_end;
    logic [7:0]         table_index;
    logic [23:0]        table_color;
    logic signed [31:0] table_threshold;
    logic               pane_colored;
  } in_item_t;

  typedef struct packed {
    logic [23:0] out_node_id;
    logic        shown;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_list_end;
  } out_item_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [23:0]        node_id;
    logic               list_end;
    logic signed [31:0] value;
    logic [31:0]        diff;
    logic               first_entry;
    logic               last_entry;
    logic [7:0]         table_index;
    logic [23:0]        table_color;
    logic signed [31:0] table_threshold;
    logic               pane_colored;
  } job_t;

endpackage

// File: hw/rtl/value_to_color_overlay_mapper.sv
// Top level of the value-to-colour overlay mapper with its configuration registers.
//
// Items enter on the in_ channel (valid/ready). Action map value yields one result
// item on the out_ channel; colour scale and pane writes load the tables and yield
// nothing. The cfg_ channel writes the five configuration registers and is always
// ready; the user must see that it is written only while the block is idle, since
// the block itself does not enforce it.
// An input stage classifies each item and places it in a four-entry queue. The back
// end then takes one item at a time: a write or a dropped node is handled as it is
// taken, a colour scale lookup goes through take, multiply, round and table read,
// and result, and a pane lookup through take, the pane search and the pane colour
// read, the pane search walking the threshold registers one per cycle.
// Results wait in an output register; while the receiver stalls, the queue fills
// and in_ready falls once it is full. Synchronous reset clears the control state
// and loads the register defaults; the tables hold no defined content until written.

`timescale 1ns / 1ps

module value_to_color_overlay_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vtcm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vtcm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vtcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import vtcm_pkg::*;

  logic               mode_r;
  logic [5:0]         pane_count_r;
  logic signed [31:0] bottom_r;
  logic signed [31:0] top_r;
  logic [31:0]        factor_r;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  job_t               q_in;
  job_t               q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      pane_count_r <= 6'd1;
      bottom_r     <= 32'sd0;
      top_r        <= 32'sd65536;
      factor_r     <= 32'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       mode_r       <= cfg_data[0];
        REG_PANE_COUNT: pane_count_r <= cfg_data[5:0];
        REG_BOTTOM:     bottom_r     <= $signed(cfg_data);
        REG_TOP:        top_r        <= $signed(cfg_data);
        REG_FACTOR:     factor_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vtcm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .colorscale_mode (mode_r),
    .scale_bottom    (bottom_r),
    .scale_top       (top_r),
    .q_push          (q_push),
    .q_data          (q_in),
    .q_full          (q_full)
  );

  vtcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  vtcm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .pane_count   (pane_count_r),
    .scale_factor (factor_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("item popped from an empty queue");
  a_shown_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.shown ==
                   ((out_data.red != 8'd0) || (out_data.green != 8'd0) ||
                    (out_data.blue != 8'd0))))
    else $error("shown flag disagrees with the colour");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

// File: hw/rtl/vtcm_front.sv
// Front end: input stage that classifies each item and forms a job for the queue.
`timescale 1ns / 1ps

module vtcm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtcm_pkg::in_item_t  in_data,
  input  logic                colorscale_mode,
  input  logic signed [31:0]  scale_bottom,
  input  logic signed [31:0]  scale_top,
  output logic                q_push,
  output vtcm_pkg::job_t      q_data,
  input  logic                q_full
);
  import vtcm_pkg::*;

  logic               stg_valid_r;
  logic               stg_valid_nxt;
  in_item_t           stg_r;
  logic               advance;
  logic               unused_act;
  logic signed [31:0] v;
  logic signed [32:0] diff_full;
  logic               ge_top;
  logic               le_bottom;
  logic               neg_drop;

  assign unused_act = (stg_r.action == ACT_UNUSED);
  assign advance    = stg_valid_r && (unused_act || !q_full);
  assign in_ready   = !stg_valid_r || advance;
  assign q_push     = stg_valid_r && !unused_act && !q_full;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (advance) begin
      stg_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_data;
    end
  end

  always_comb begin
    v         = $signed(stg_r.value);
    diff_full = {scale_top[31], scale_top} - {v[31], v};
    ge_top    = (v >= scale_top);
    le_bottom = (v <= scale_bottom);
    neg_drop  = (scale_bottom == 32'sd0) && (v < 32'sd0);

    q_data                 = '0;
    q_data.node_id         = stg_r.node_id;
    q_data.list_end        = stg_r.list_end;
    q_data.value           = v;
    q_data.diff            = diff_full[31:0];
    q_data.first_entry     = ge_top;
    q_data.last_entry      = !ge_top && le_bottom;
    q_data.table_index     = stg_r.table_index;
    q_data.table_color     = stg_r.table_color;
    q_data.table_threshold = stg_r.table_threshold;
    q_data.pane_colored    = stg_r.pane_colored;

    case (stg_r.action)
      ACT_CS_WRITE: begin
        q_data.kind = JOB_CS_WRITE;
      end
      ACT_PANE_WRITE: begin
        q_data.kind = JOB_PANE_WRITE;
      end
      ACT_MAP: begin
        if (colorscale_mode) begin
          q_data.kind = neg_drop ? JOB_DROP : JOB_MAP_CS;
        end else begin
          q_data.kind = (v == 32'sd0) ? JOB_DROP : JOB_MAP_PANE;
        end
      end
      default: begin
        q_data.kind = JOB_DROP;
      end
    endcase
  end

endmodule

// File: hw/rtl/vtcm_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module vtcm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vtcm_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output vtcm_pkg::job_t  head,
  output logic            empty
);
  import vtcm_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign full  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/vtcm_back.sv
// Back end: table writes, colour scale lookup, pane search and the result register.
`timescale 1ns / 1ps

module vtcm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vtcm_pkg::job_t      q_head,
  output logic                q_pop,
  input  logic [5:0]          pane_count,
  input  logic [31:0]         scale_factor,
  output logic                out_valid,
  input  logic                out_ready,
  output vtcm_pkg::out_item_t out_data
);
  import vtcm_pkg::*;

  back_state_t             state_r;
  back_state_t             state_nxt;
  job_t                    job_r;
  job_t                    job_nxt;
  logic [63:0]             prod_r;
  logic [63:0]             prod_nxt;
  logic [PANE_IDX_W-1:0]   pane_i_r;
  logic [PANE_IDX_W-1:0]   pane_i_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_item_t               out_r;
  out_item_t               out_nxt;

  logic [23:0]             cs_mem_r [COLORSCALE_ENTRIES];
  logic [24:0]             pc_mem_r [MAX_PANES + 1];
  logic signed [31:0]      thr_r [MAX_PANES];
  logic [23:0]             cs_rd_r;
  logic [24:0]             pc_rd_r;

  logic                    cs_we;
  logic                    cs_re;
  logic [CS_IDX_W-1:0]     cs_waddr;
  logic [CS_IDX_W-1:0]     cs_raddr;
  logic                    pc_we;
  logic                    pc_re;
  logic [PANE_IDX_W-1:0]   pc_waddr;
  logic [PANE_IDX_W-1:0]   pc_raddr;
  logic                    thr_we;
  logic [PANE_ADDR_W-1:0]  thr_waddr;

  logic                    slot_free;
  logic [PANE_IDX_W-1:0]   np;
  logic [64:0]             rsum;
  logic [32:0]             rhi;
  logic [23:0]             color;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    if (pane_count == 6'd0) begin
      np = PANE_IDX_W'(1);
    end else if (int'(pane_count) > MAX_PANES) begin
      np = PANE_IDX_W'(MAX_PANES);
    end else begin
      np = PANE_IDX_W'(pane_count);
    end
  end

  assign cs_waddr  = CS_IDX_W'(q_head.table_index);
  assign pc_waddr  = PANE_IDX_W'(q_head.table_index);
  assign thr_waddr = PANE_ADDR_W'(q_head.table_index);

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    prod_nxt      = prod_r;
    pane_i_nxt    = pane_i_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    cs_we         = 1'b0;
    cs_re         = 1'b0;
    cs_raddr      = '0;
    pc_we         = 1'b0;
    pc_re         = 1'b0;
    pc_raddr      = '0;
    thr_we        = 1'b0;
    rsum          = {1'b0, prod_r} + {1'b0, ROUND_Q32};
    rhi           = rsum[64:32];
    color         = '0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            JOB_DROP: begin
              if (slot_free) begin
                q_pop                 = 1'b1;
                out_valid_nxt         = 1'b1;
                out_nxt               = '0;
                out_nxt.out_node_id   = q_head.node_id;
                out_nxt.out_list_end  = q_head.list_end;
              end
            end
            JOB_CS_WRITE: begin
              q_pop = 1'b1;
              cs_we = (int'(q_head.table_index) < COLORSCALE_ENTRIES);
            end
            JOB_PANE_WRITE: begin
              q_pop  = 1'b1;
              thr_we = (int'(q_head.table_index) < MAX_PANES);
              pc_we  = (int'(q_head.table_index) <= MAX_PANES);
            end
            JOB_MAP_CS: begin
              q_pop     = 1'b1;
              job_nxt   = q_head;
              state_nxt = ST_MUL;
            end
            JOB_MAP_PANE: begin
              q_pop      = 1'b1;
              job_nxt    = q_head;
              pane_i_nxt = '0;
              state_nxt  = ST_SEARCH;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = 64'(job_r.diff) * 64'(scale_factor);
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        cs_re = 1'b1;
        if (job_r.first_entry) begin
          cs_raddr = '0;
        end else if (job_r.last_entry || (rhi > 33'(CS_LAST))) begin
          cs_raddr = CS_LAST;
        end else begin
          cs_raddr = rhi[CS_IDX_W-1:0];
        end
        state_nxt = ST_CS_RD;
      end
      ST_CS_RD: begin
        if (slot_free) begin
          color                = cs_rd_r;
          out_valid_nxt        = 1'b1;
          out_nxt.out_node_id  = job_r.node_id;
          out_nxt.out_list_end = job_r.list_end;
          out_nxt.shown        = (color != 24'd0);
          out_nxt.red          = color[23:16];
          out_nxt.green        = color[15:8];
          out_nxt.blue         = color[7:0];
          state_nxt            = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if ((pane_i_r < np) &&
            ($signed(job_r.value) < thr_r[pane_i_r[PANE_ADDR_W-1:0]])) begin
          pane_i_nxt = pane_i_r + 1'b1;
        end else begin
          pc_re     = 1'b1;
          pc_raddr  = pane_i_r;
          state_nxt = ST_PANE_RD;
        end
      end
      ST_PANE_RD: begin
        if (slot_free) begin
          color                = pc_rd_r[24] ? pc_rd_r[23:0] : 24'd0;
          out_valid_nxt        = 1'b1;
          out_nxt.out_node_id  = job_r.node_id;
          out_nxt.out_list_end = job_r.list_end;
          out_nxt.shown        = (color != 24'd0);
          out_nxt.red          = color[23:16];
          out_nxt.green        = color[15:8];
          out_nxt.blue         = color[7:0];
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    prod_r   <= prod_nxt;
    pane_i_r <= pane_i_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem_r[cs_waddr] <= q_head.table_color;
    end
    if (cs_re) begin
      cs_rd_r <= cs_mem_r[cs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem_r[pc_waddr] <= {q_head.pane_colored, q_head.table_color};
    end
    if (pc_re) begin
      pc_rd_r <= pc_mem_r[pc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_r[thr_waddr] <= q_head.table_threshold;
    end
  end

endmodule
